[rtl/rgbwwpbl_pkg.sv]
// ----------------------------------------------------------------------------
// rgbwwpbl_pkg
// Shared constants and register codes for the RGBWW power budget limiter.
// ----------------------------------------------------------------------------
package rgbwwpbl_pkg;

  localparam int LEVEL_BITS_DEFAULT  = 16;
  localparam int WEIGHT_BITS_DEFAULT = 8;

  // channel order, also the lane order in tdata
  localparam int NCH      = 5;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_COLD  = 3;
  localparam int CH_WARM  = 4;

  // power fraction register, 65535 stands for 1.0
  localparam int                FRAC_W    = 16;
  localparam logic [FRAC_W-1:0] FRAC_FULL = 16'd65535;
  localparam logic [FRAC_W-1:0] FRAC_MIN  = 16'd655;

  // scale is unsigned Q0.16; below SCALE_LIMIT (0.999, rounded up) counts as limiting
  localparam int                 SCALE_BITS  = 16;
  localparam logic [SCALE_BITS-1:0] SCALE_LIMIT = 16'd65471;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WEIGHT_RED     = 3'd0,
    REG_WEIGHT_GREEN   = 3'd1,
    REG_WEIGHT_BLUE    = 3'd2,
    REG_WEIGHT_COLD    = 3'd3,
    REG_WEIGHT_WARM    = 3'd4,
    REG_POWER_FRACTION = 3'd5,
    REG_INTERLOCK      = 3'd6
  } cfg_reg_t;

endpackage

[rtl/rgbww_power_budget_limiter_unit.sv]
// ----------------------------------------------------------------------------
// rgbww_power_budget_limiter_unit
// Holds each set of five LED drive levels to a programmable power budget.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                          | tuser
//  --------+-----------+---------------------------------------------+-----------
//  in_     | slave     | red, green, blue, cold, warm, brightness_req | rgb_mode
//  out_    | master    | red, green, blue, cold, warm, brightness_shown | limited
//  cfg_    | slave     | cfg_index selects register, cfg_data value  | -
//
//  One transaction per cycle in and out while neither side stalls. Pipeline:
//  three front-end stages, one restoring divider stage per scale bit, one
//  multiply stage and the output register.
//  Reset (rst_n, synchronous) empties the pipeline and restores the registers.
//  A stalled output parks one result in a skid register; in_tready drops only
//  while that skid register is full, and then the whole pipeline holds.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgbww_power_budget_limiter_unit #(
  parameter int LEVEL_BITS  = rgbwwpbl_pkg::LEVEL_BITS_DEFAULT,
  parameter int WEIGHT_BITS = rgbwwpbl_pkg::WEIGHT_BITS_DEFAULT,
  localparam int DATA_W     = ((6 * LEVEL_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // red, green, blue, cold, warm, brightness_request
  input  logic [DATA_W-1:0]                    in_tdata,
  // rgb_mode
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // red, green, blue, cold, warm, brightness_shown
  output logic [DATA_W-1:0]                    out_tdata,
  // limited
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgbwwpbl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbwwpbl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NCH       = rgbwwpbl_pkg::NCH;
  localparam int L         = LEVEL_BITS;
  localparam int W         = WEIGHT_BITS;
  localparam int FRAC_W    = rgbwwpbl_pkg::FRAC_W;
  localparam int SCALE_W   = rgbwwpbl_pkg::SCALE_BITS;
  localparam int DIV_STEPS = SCALE_W;
  localparam int PROD_W    = L + W;
  localparam int SUM_W     = PROD_W + 3;
  localparam int WT_W      = W + 3;
  localparam int PFW_W     = FRAC_W + WT_W;
  localparam int CMP_W     = SUM_W + FRAC_W;   // equals PFW_W + L
  localparam int MUL_W     = L + SCALE_W;
  localparam int LEVEL_MAX = (1 << L) - 1;
  localparam logic [L-1:0] MIN_LEVEL = L'((LEVEL_MAX + 50) / 100);

  typedef struct packed {
    logic [NCH-1:0][L-1:0] lvl;
    logic [L-1:0]          req;
  } item_t;

  typedef struct packed {
    logic [NCH-1:0][L-1:0] lvl;
    logic [L-1:0]          shown;
    logic                  lim;
  } res_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [NCH-1:0][W-1:0] weight_r;
  logic [FRAC_W-1:0]     pf_r;
  logic                  ilk_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        weight_r[i] <= W'(1);
      end
      pf_r  <= rgbwwpbl_pkg::FRAC_FULL;
      ilk_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbwwpbl_pkg::REG_WEIGHT_RED:   weight_r[rgbwwpbl_pkg::CH_RED]   <= cfg_data[W-1:0];
        rgbwwpbl_pkg::REG_WEIGHT_GREEN: weight_r[rgbwwpbl_pkg::CH_GREEN] <= cfg_data[W-1:0];
        rgbwwpbl_pkg::REG_WEIGHT_BLUE:  weight_r[rgbwwpbl_pkg::CH_BLUE]  <= cfg_data[W-1:0];
        rgbwwpbl_pkg::REG_WEIGHT_COLD:  weight_r[rgbwwpbl_pkg::CH_COLD]  <= cfg_data[W-1:0];
        rgbwwpbl_pkg::REG_WEIGHT_WARM:  weight_r[rgbwwpbl_pkg::CH_WARM]  <= cfg_data[W-1:0];
        rgbwwpbl_pkg::REG_POWER_FRACTION: begin
          pf_r <= (cfg_data[FRAC_W-1:0] < rgbwwpbl_pkg::FRAC_MIN) ?
                  rgbwwpbl_pkg::FRAC_MIN : cfg_data[FRAC_W-1:0];
        end
        rgbwwpbl_pkg::REG_INTERLOCK:    ilk_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves unless the skid register is occupied
  // --------------------------------------------------------------------------
  logic skid_v_r;
  logic adv;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // stage 1: interlock, per-channel weighted products, budget product
  // --------------------------------------------------------------------------
  item_t                     s1_item_nxt, s1_item_r;
  logic [NCH-1:0][PROD_W-1:0] s1_prod_nxt, s1_prod_r;
  logic [PFW_W-1:0]          s1_pfw_nxt, s1_pfw_r;
  logic [WT_W-1:0]           wt_sum;
  logic                      s1_v_r;

  always_comb begin
    s1_item_nxt.lvl = in_tdata[NCH*L-1:0];
    s1_item_nxt.req = in_tdata[(NCH+1)*L-1:NCH*L];
    if (ilk_r) begin
      if (in_tuser) begin
        s1_item_nxt.lvl[rgbwwpbl_pkg::CH_COLD] = '0;
        s1_item_nxt.lvl[rgbwwpbl_pkg::CH_WARM] = '0;
      end else begin
        s1_item_nxt.lvl[rgbwwpbl_pkg::CH_RED]   = '0;
        s1_item_nxt.lvl[rgbwwpbl_pkg::CH_GREEN] = '0;
        s1_item_nxt.lvl[rgbwwpbl_pkg::CH_BLUE]  = '0;
      end
    end
    wt_sum = '0;
    for (int i = 0; i < NCH; i++) begin
      wt_sum         = wt_sum + WT_W'(weight_r[i]);
      s1_prod_nxt[i] = PROD_W'(s1_item_nxt.lvl[i]) * PROD_W'(weight_r[i]);
    end
    s1_pfw_nxt = PFW_W'(pf_r) * PFW_W'(wt_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= s1_item_nxt;
      s1_prod_r <= s1_prod_nxt;
      s1_pfw_r  <= s1_pfw_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: weighted sum, budget in common unit (x LEVEL_MAX)
  // --------------------------------------------------------------------------
  item_t            s2_item_r;
  logic [SUM_W-1:0] s2_sum_nxt, s2_sum_r;
  logic [CMP_W-1:0] s2_bcmp_nxt, s2_bcmp_r;
  logic             s2_v_r;

  always_comb begin
    s2_sum_nxt = '0;
    for (int i = 0; i < NCH; i++) begin
      s2_sum_nxt = s2_sum_nxt + SUM_W'(s1_prod_r[i]);
    end
    s2_bcmp_nxt = {s1_pfw_r, {L{1'b0}}} - CMP_W'(s1_pfw_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r <= s1_item_r;
      s2_sum_r  <= s2_sum_nxt;
      s2_bcmp_r <= s2_bcmp_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3 and divider: entry 0 holds sum x FRAC_FULL as divisor and the
  // budget as partial remainder; each further entry resolves one scale bit
  // --------------------------------------------------------------------------
  logic             div_v_r    [0:DIV_STEPS];
  item_t            div_item_r [0:DIV_STEPS];
  logic [CMP_W-1:0] div_den_r  [0:DIV_STEPS];
  logic [CMP_W:0]   div_rem_r  [0:DIV_STEPS];
  logic [SCALE_W-1:0] div_q_r  [0:DIV_STEPS];
  logic             div_over_r [1:DIV_STEPS];
  logic [CMP_W-1:0] s3_den_nxt;

  assign s3_den_nxt = {s2_sum_r, {FRAC_W{1'b0}}} - CMP_W'(s2_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r[0] <= 1'b0;
    end else if (adv) begin
      div_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_item_r[0] <= s2_item_r;
      div_den_r[0]  <= s3_den_nxt;
      div_rem_r[0]  <= (CMP_W+1)'(s2_bcmp_r);
      div_q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [CMP_W:0] trial;
    logic           take;

    assign trial = {div_rem_r[k][CMP_W-1:0], 1'b0};
    assign take  = trial >= {1'b0, div_den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        div_v_r[k+1] <= div_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_item_r[k+1] <= div_item_r[k];
        div_den_r[k+1]  <= div_den_r[k];
        div_rem_r[k+1]  <= take ? (trial - {1'b0, div_den_r[k]}) : trial;
        div_q_r[k+1]    <= {div_q_r[k][SCALE_W-2:0], take};
      end
    end

    // over-budget test runs alongside the first step; scale only counts if set
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          div_over_r[1] <= div_den_r[0] > div_rem_r[0][CMP_W-1:0];
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) begin
          div_over_r[k+1] <= div_over_r[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // multiply stage: every level and the request times the scale
  // --------------------------------------------------------------------------
  item_t                 mul_item_r;
  logic [NCH-1:0][L-1:0] mul_sc_nxt, mul_sc_r;
  logic [L-1:0]          mul_shsc_nxt, mul_shsc_r;
  logic                  mul_lim_nxt, mul_lim_r;
  logic                  mul_v_r;

  always_comb begin
    logic [MUL_W-1:0] full;
    logic [MUL_W-1:0] full_req;
    for (int i = 0; i < NCH; i++) begin
      full          = MUL_W'(div_item_r[DIV_STEPS].lvl[i]) * MUL_W'(div_q_r[DIV_STEPS]);
      mul_sc_nxt[i] = full[MUL_W-1:SCALE_W];
    end
    full_req     = MUL_W'(div_item_r[DIV_STEPS].req) * MUL_W'(div_q_r[DIV_STEPS]);
    mul_shsc_nxt = full_req[MUL_W-1:SCALE_W];
    mul_lim_nxt  = div_over_r[DIV_STEPS] &&
                   (div_q_r[DIV_STEPS] < rgbwwpbl_pkg::SCALE_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (adv) begin
      mul_v_r <= div_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_item_r <= div_item_r[DIV_STEPS];
      mul_sc_r   <= mul_sc_nxt;
      mul_shsc_r <= mul_shsc_nxt;
      mul_lim_r  <= mul_lim_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result select, output register and skid register
  // --------------------------------------------------------------------------
  res_t res;
  res_t out_r, skid_r;
  logic out_v_r;

  always_comb begin
    res.lim = mul_lim_r;
    if (mul_lim_r) begin
      res.lvl   = mul_sc_r;
      res.shown = (mul_shsc_r < MIN_LEVEL) ? MIN_LEVEL : mul_shsc_r;
    end else begin
      res.lvl   = mul_item_r.lvl;
      res.shown = mul_item_r.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= mul_v_r;
      end
    end else if (adv && mul_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (adv) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = DATA_W'({out_r.shown, out_r.lvl});
  assign out_tuser  = out_r.lim;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid register filled without an output stall");

  a_frac_floor: assert property (@(posedge clk) disable iff (!rst_n)
    pf_r >= rgbwwpbl_pkg::FRAC_MIN)
    else $error("power fraction below its floor");

  a_shown_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.lim) |-> (out_r.shown >= MIN_LEVEL))
    else $error("limited result with brightness below the floor");

endmodule
